@@ design/lj2_pkg.sv @@
package lj2_pkg;

  localparam int unsigned BLOCK_LEN = 12;
  localparam int unsigned MIX_STAGES = 9;
  localparam logic [31:0] GOLDEN_WORD = 32'h9E3779B9;
  localparam logic [31:0] SEED_RESET = 32'h12345678;

  localparam int unsigned MIX_SHIFT [MIX_STAGES] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } abc_t;

  // blk: a full block to absorb; fin: end of message.
  // wa/wb/wc: block words, or leftover words of a final-only request.
  // fc: leftover c bytes (shifted up one byte) plus the length.
  // The message's start value of c is folded into wc on its first block,
  // or into fc when no block comes before the end.
  typedef struct packed {
    logic  blk;
    logic  fin;
    word_t wa;
    word_t wb;
    word_t wc;
    word_t fc;
  } job_t;

  // One line of the lookup2 mix; lines cycle through targets a, b, c.
  function automatic abc_t mix_step(input logic [3:0] k, input abc_t v);
    abc_t r;
    r = v;
    case (k)
      4'd0, 4'd3, 4'd6: r.a = (v.a - v.b - v.c) ^ (v.c >> MIX_SHIFT[k]);
      4'd1, 4'd4, 4'd7: r.b = (v.b - v.c - v.a) ^ (v.a << MIX_SHIFT[k]);
      default:          r.c = (v.c - v.a - v.b) ^ (v.b >> MIX_SHIFT[k]);
    endcase
    return r;
  endfunction

endpackage

@@ design/jenkins_lookup2_string_hash.sv @@
// Channel  Dir  Signals                       Contents
// in_      in   tvalid tready tdata tlast tuser   at most one message byte per request
// out_     out  tvalid tready tdata              32-bit hash, one per message
// cfg_     in   wr_en wr_data                    seed (initial c), reset 0x12345678
//
// Takes one byte per cycle while the request queue has room. A 12-byte block is absorbed
// by a 9-stage mix pipeline (one mix line per stage); a message end's hash is registered
// from the last mix stage. An end that follows a completed block waits for that block's mix;
// the request queue (QUEUE_DEPTH deep) keeps input flowing meanwhile.
// Synchronous active-low reset; no clearing pass. Output stall holds the mix pipeline.
module jenkins_lookup2_string_hash #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] byte_value
  input  logic        in_tlast,     // last_byte
  input  logic        in_tuser,     // [0] no_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] hash_value
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import lj2_pkg::*;

  job_t push_job, head;
  logic push, q_full, q_valid, pop;

  lj2_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  lj2_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  lj2_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ design/lj2_front.sv @@
module lj2_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          in_tuser,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          q_full,
  output logic          push,
  output lj2_pkg::job_t push_job
);
  import lj2_pkg::*;

  logic [7:0] buf_r [BLOCK_LEN];
  logic [7:0] bytes_w [BLOCK_LEN];
  logic [7:0] mb [BLOCK_LEN];
  logic [3:0] fill_r, fill_nxt;
  word_t      len_r, len_nxt;
  word_t      seed_r, mseed_r, mseed_nxt;
  logic       first_r, first_nxt;
  logic       acc, has_byte, full, blk, fin;
  logic [3:0] cnt_inc, cntm;
  word_t      len_inc, left_c, seed_add;

  assign in_tready = !q_full;

  always_comb begin
    acc      = in_tvalid && !q_full;
    has_byte = acc && !in_tuser;
    cnt_inc  = fill_r + 4'd1;
    full     = (cnt_inc == 4'(BLOCK_LEN));
    cntm     = in_tuser ? fill_r : cnt_inc;
    len_inc  = len_r + {31'b0, !in_tuser};
    blk      = has_byte && full;
    fin      = acc && in_tlast;
    for (int k = 0; k < BLOCK_LEN; k++) begin
      bytes_w[k] = (has_byte && fill_r == 4'(k)) ? in_tdata : buf_r[k];
      mb[k]      = (4'(k) < cntm) ? bytes_w[k] : 8'h00;
    end
    seed_add = first_r ? mseed_r : 32'h0;
    left_c = blk ? 32'h0 : {mb[10], mb[9], mb[8], 8'h00};
    push_job.blk = blk;
    push_job.fin = fin;
    push_job.wa  = {mb[3], mb[2], mb[1], mb[0]};
    push_job.wb  = {mb[7], mb[6], mb[5], mb[4]};
    push_job.wc  = {mb[11], mb[10], mb[9], mb[8]} + seed_add;
    push_job.fc  = left_c + len_inc + (blk ? 32'h0 : seed_add);
    push         = blk || fin;

    fill_nxt  = fill_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    mseed_nxt = mseed_r;
    if (acc) begin
      if (fin) begin
        fill_nxt  = 4'd0;
        len_nxt   = 32'h0;
        first_nxt = 1'b1;
        mseed_nxt = seed_r;
      end else if (has_byte) begin
        fill_nxt = full ? 4'd0 : cnt_inc;
        len_nxt  = len_inc;
        if (blk) begin
          first_nxt = 1'b0;
        end
      end
    end
    // new seed reaches the open message only while it has taken no byte
    if (cfg_wr_en && ((fill_r == 4'd0 && len_r == 32'h0) || fin)) begin
      mseed_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (has_byte) begin
      buf_r[fill_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= 4'd0;
      len_r   <= 32'h0;
      seed_r  <= SEED_RESET;
      mseed_r <= SEED_RESET;
      first_r <= 1'b1;
    end else begin
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      mseed_r <= mseed_nxt;
      first_r <= first_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ design/lj2_queue.sv @@
module lj2_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lj2_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output lj2_pkg::job_t head
);
  import lj2_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/lj2_back.sv @@
module lj2_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lj2_pkg::job_t head,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata
);
  import lj2_pkg::*;

  abc_t                st_r [MIX_STAGES + 1];
  logic [MIX_STAGES:0] v_r, f_r;
  word_t               a_r, b_r, c_r;
  logic                fresh_r, busy_r, part_r;
  logic                out_valid_r;
  word_t               out_hash_r;
  logic                adv, issue, blk_issue, wback, done;
  word_t               ea, eb, ec;
  abc_t                st0_nxt;

  assign done  = v_r[MIX_STAGES] && f_r[MIX_STAGES];
  assign adv   = !(done && out_valid_r && !out_tready);
  assign wback = adv && v_r[MIX_STAGES] && !f_r[MIX_STAGES];

  always_comb begin
    blk_issue = head.blk && !part_r;
    issue     = adv && q_valid && !busy_r;
    pop       = issue && (!blk_issue || !head.fin);
    ea        = fresh_r ? GOLDEN_WORD : a_r;
    eb        = fresh_r ? GOLDEN_WORD : b_r;
    ec        = fresh_r ? 32'h0 : c_r;
    st0_nxt.a = ea + (part_r ? 32'h0 : head.wa);
    st0_nxt.b = eb + (part_r ? 32'h0 : head.wb);
    st0_nxt.c = ec + (blk_issue ? head.wc : head.fc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar g = 1; g <= MIX_STAGES; g++) begin : g_mix
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= mix_step(4'(g - 1), st_r[g - 1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wback) begin
      a_r <= st_r[MIX_STAGES].a;
      b_r <= st_r[MIX_STAGES].b;
      c_r <= st_r[MIX_STAGES].c;
    end
    if (adv && done) begin
      out_hash_r <= st_r[MIX_STAGES].c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      f_r         <= '0;
      fresh_r     <= 1'b1;
      busy_r      <= 1'b0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= {v_r[MIX_STAGES-1:0], issue};
        f_r <= {f_r[MIX_STAGES-1:0], issue && !blk_issue};
      end
      if (issue && blk_issue) begin
        busy_r <= 1'b1;
        part_r <= head.fin;
      end else if (issue) begin
        fresh_r <= 1'b1;
        part_r  <= 1'b0;
      end
      if (wback) begin
        busy_r  <= 1'b0;
        fresh_r <= 1'b0;
      end
      if (adv && done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_hash_r;

  a_busy_tracks_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == ($countones(v_r & ~f_r) == 1))
    else $error("busy flag out of step with block mixes in flight");

  a_wback_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wback |-> busy_r)
    else $error("block writeback without a block in flight");

  a_part_on_combined: assert property (@(posedge clk) disable iff (!rst_n)
    part_r |-> (q_valid && head.blk && head.fin))
    else $error("split request flag set without a combined request at head");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef enum int {RDY_FULL, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} rdy_mode_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_e;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned BLOCK_BYTES = 12;
  localparam logic [31:0] GOLDEN = lj2_pkg::GOLDEN_WORD;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] byte_value
  logic        in_tlast;     // last_byte
  logic        in_tuser;     // [0] no_data
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] hash_value
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  jenkins_lookup2_string_hash i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted hash state
  logic [31:0] seed_q;
  logic [7:0]  msg_bytes [BLOCK_BYTES];
  int unsigned fill_cnt;
  logic [31:0] word_a, word_b, word_c, msg_len;
  logic [31:0] hash_q [$];
  logic [31:0] exp_hash;
  int unsigned errors;
  int unsigned cycles;

  // sender / receiver pacing
  bit          bursty;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rdy_left;
  int unsigned rdy_tick;
  rdy_mode_e   rdy_mode;

  function automatic void lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                                      inout logic [31:0] c);
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
  endfunction

  function automatic logic [31:0] block_word(input int unsigned base);
    return {msg_bytes[base + 3], msg_bytes[base + 2], msg_bytes[base + 1], msg_bytes[base]};
  endfunction

  function automatic void start_hash();
    fill_cnt = 0;
    word_a = GOLDEN;
    word_b = GOLDEN;
    word_c = seed_q;
    msg_len = '0;
  endfunction

  function automatic void hash_absorb(input logic [7:0] data, input logic last,
                                      input logic no_data);
    logic [31:0] a, b, c, v;
    int unsigned i;
    if (!no_data) begin
      msg_bytes[fill_cnt] = data;
      fill_cnt++;
      msg_len++;
      if (fill_cnt == BLOCK_BYTES) begin
        word_a += block_word(0);
        word_b += block_word(4);
        word_c += block_word(8);
        lookup2_mix(word_a, word_b, word_c);
        fill_cnt = 0;
      end
    end
    if (last) begin
      a = word_a;
      b = word_b;
      c = word_c + msg_len;
      for (i = 0; i < fill_cnt; i++) begin
        v = {24'h0, msg_bytes[i]};
        if (i < 4)
          a += v << (8 * i);
        else if (i < 8)
          b += v << (8 * (i - 4));
        else
          c += v << (8 * (i - 8) + 8);
      end
      lookup2_mix(a, b, c);
      hash_q = {hash_q, c};
      start_hash();
    end
  endfunction

  // seed writes and accepted requests feed the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_q = lj2_pkg::SEED_RESET;
      start_hash();
    end else begin
      if (cfg_wr_en) begin
        seed_q = cfg_wr_data;
        if (fill_cnt == 0 && msg_len == 0)
          word_c = seed_q;
      end
      if (in_tvalid && in_tready)
        hash_absorb(in_tdata, in_tlast, in_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_q.size() == 0) begin
        errors++;
        $display("%0t: hash with none pending: expected none, actual %08h", $time, out_tdata);
      end else begin
        exp_hash = hash_q.pop_front();
        if (out_tdata !== exp_hash) begin
          errors++;
          $display("%0t: hash_value: expected %08h, actual %08h", $time, exp_hash, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_e'($urandom_range(0, 3));
      rdy_left = $urandom_range(8, 80);
    end else begin
      rdy_left--;
    end
    rdy_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rdy_mode)
        RDY_FULL:   out_tready <= 1'b1;
        RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:    out_tready <= (rdy_tick % 4) != 3;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("jenkins_lookup2_string_hash: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] data, input logic last, input logic no_data);
    if (bursty && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0)
      burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    in_tuser  <= no_data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_message(input int unsigned len, input fill_mode_e fill,
                              input bit empty_end, input bit noise);
    logic [7:0] data;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 15) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      case (fill)
        FILL_ZERO: data = 8'h00;
        FILL_ONES: data = 8'hFF;
        default:   data = 8'($urandom_range(0, 255));
      endcase
      send_request(data, (i == len - 1) && !empty_end, 1'b0);
    end
    if (len == 0 || empty_end)
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // sender waits out every pending hash, then the pipeline tail
  task automatic drain();
    in_tvalid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_directed_messages();
    bursty = 1'b0;
    send_message(0, FILL_RANDOM, 1'b0, 1'b0);
    send_message(1, FILL_ONES, 1'b0, 1'b0);
    send_message(12, FILL_ONES, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    send_message(4, FILL_ZERO, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_seed_values();
    write_seed(32'h0000_0000);
    send_message(0, FILL_RANDOM, 1'b0, 1'b0);
    send_message(3, FILL_RANDOM, 1'b0, 1'b0);
    drain();
    write_seed(32'hFFFF_FFFF);
    send_message(2, FILL_ONES, 1'b0, 1'b0);
    drain();
    // empty request opens the message; seed lands before its first byte
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    drain();
    write_seed($urandom());
    send_message(3, FILL_RANDOM, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_input_stall();
    int unsigned i;
    bursty = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 60; i++)
      send_message($urandom_range(1, 2), FILL_RANDOM, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random_messages();
    int unsigned sent, len, pick;
    sent = 0;
    while (sent < 1000) begin
      pick = $urandom_range(0, 19);
      bursty = ($urandom_range(0, 3) != 0);
      if (pick == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0:       write_seed(32'h0000_0000);
          1:       write_seed(32'hFFFF_FFFF);
          2:       write_seed(lj2_pkg::SEED_RESET);
          default: write_seed($urandom());
        endcase
      end
      if (pick <= 2)
        len = 0;
      else if (pick == 3)
        len = $urandom_range(30, 120);
      else
        len = $urandom_range(1, 26);
      send_message(len, FILL_RANDOM, ($urandom_range(0, 3) == 0), 1'b1);
      sent += (len == 0) ? 1 : len;
    end
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    bursty = 1'b0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_left = 0;
    rdy_left = 0;
    rdy_tick = 0;
    rdy_mode = RDY_FULL;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 32'h0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_messages();
    test_seed_values();
    test_input_stall();
    test_random_messages();
    if (errors == 0)
      $display("jenkins_lookup2_string_hash: match");
    else
      $display("jenkins_lookup2_string_hash: mismatch");
    $finish;
  end

endmodule
